[hdl/hsplit_pkg.sv]
package hsplit_pkg;

  localparam int WINDOW_BYTES = 2048;
  localparam int ADDR_W       = $clog2(WINDOW_BYTES);
  localparam int CNT_W        = ADDR_W + 1;
  localparam int OFFSET_WIDTH = 24;
  localparam int OFF_OUT_W    = 24;
  localparam int LEN_W        = 11;
  localparam int TS_W         = 32;
  localparam int DATA_W       = 8;
  localparam int MPS_W        = 12;
  localparam int MPS_RESET    = 1400;
  localparam int MPS_MIN      = 3;
  localparam int HDR_BYTES    = 2;
  localparam int PADDR_W      = 3;
  localparam int PDATA_W      = 32;

  localparam logic [PADDR_W-1:0] REG_MAX_PAYLOAD = PADDR_W'(0);

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic [OFF_OUT_W-1:0] off;
    logic [LEN_W-1:0]     len;
    logic                 pic;
    logic                 mark;
    logic [TS_W-1:0]      ts;
  } desc_t;

endpackage

[hdl/hsplit_if.sv]
interface hsplit_in_if;
  logic                           valid;
  logic                           ready;
  logic [hsplit_pkg::DATA_W-1:0]  data_byte;
  logic                           frame_last;
  logic [hsplit_pkg::TS_W-1:0]    frame_timestamp;

  modport source(output valid, data_byte, frame_last, frame_timestamp, input ready);
  modport sink(input valid, data_byte, frame_last, frame_timestamp, output ready);
endinterface

interface hsplit_out_if;
  logic                             valid;
  logic                             ready;
  logic [hsplit_pkg::OFF_OUT_W-1:0] payload_offset;
  logic [hsplit_pkg::LEN_W-1:0]     payload_length;
  logic                             picture_start;
  logic                             marker;
  logic [hsplit_pkg::TS_W-1:0]      packet_timestamp;
  logic                             last_result;

  modport source(output valid, payload_offset, payload_length, picture_start, marker,
                 packet_timestamp, last_result, input ready);
  modport sink(input valid, payload_offset, payload_length, picture_start, marker,
               packet_timestamp, last_result, output ready);
endinterface

[hdl/hsplit_ram.sv]
module hsplit_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/hsplit_cfg.sv]
module hsplit_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [hsplit_pkg::PADDR_W-1:0]    paddr,
  input  logic [hsplit_pkg::PDATA_W-1:0]    pwdata,
  output logic [hsplit_pkg::PDATA_W-1:0]    prdata,
  output logic                              pready,
  output logic [hsplit_pkg::ADDR_W-1:0]     frame_limit
);

  logic [hsplit_pkg::MPS_W-1:0] mps_r;
  int unsigned                  m;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mps_r <= hsplit_pkg::MPS_W'(hsplit_pkg::MPS_RESET);
    end else if (psel && penable && pwrite && paddr == hsplit_pkg::REG_MAX_PAYLOAD) begin
      mps_r <= pwdata[hsplit_pkg::MPS_W-1:0];
    end
  end

  always_comb begin
    m = int'(mps_r);
    if (m < hsplit_pkg::MPS_MIN) begin
      m = hsplit_pkg::MPS_MIN;
    end else if (m > hsplit_pkg::WINDOW_BYTES) begin
      m = hsplit_pkg::WINDOW_BYTES;
    end
    frame_limit = hsplit_pkg::ADDR_W'(m - hsplit_pkg::HDR_BYTES);
  end

  assign pready = 1'b1;
  assign prdata = (paddr == hsplit_pkg::REG_MAX_PAYLOAD) ?
                  hsplit_pkg::PDATA_W'(mps_r) : '0;

endmodule

[hdl/hsplit_ctrl.sv]
module hsplit_ctrl (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [hsplit_pkg::DATA_W-1:0]     in_data_byte,
  input  logic                              in_frame_last,
  input  logic [hsplit_pkg::TS_W-1:0]       in_frame_timestamp,
  output logic                              out_valid,
  input  logic                              out_ready,
  output hsplit_pkg::desc_t                 out_desc,
  output logic                              out_last,
  input  logic [hsplit_pkg::ADDR_W-1:0]     frame_limit,
  output hsplit_pkg::mem_req_t              mem_req,
  input  logic [hsplit_pkg::DATA_W-1:0]     mem_rdata
);

  localparam int AW = hsplit_pkg::ADDR_W;
  localparam int CW = hsplit_pkg::CNT_W;
  localparam int DW = hsplit_pkg::DATA_W;
  localparam int OW = hsplit_pkg::OFFSET_WIDTH;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_LOOP = 8'b0000_0010,
    ST_PIC0 = 8'b0000_0100,
    ST_PIC1 = 8'b0000_1000,
    ST_PIC2 = 8'b0001_0000,
    ST_SRCH = 8'b0010_0000,
    ST_EMIT = 8'b0100_0000,
    ST_FIN  = 8'b1000_0000
  } state_t;

  state_t               state_r, state_nxt;
  logic                 open_r, open_nxt;
  logic [CW-1:0]        fill_r, fill_nxt;
  logic [AW-1:0]        head_r, head_nxt;
  logic [OW-1:0]        base_r, base_nxt;
  logic [hsplit_pkg::TS_W-1:0] ts_r, ts_nxt;
  logic [AW-1:0]        lim_r, lim_nxt;
  logic                 pknown_r, pknown_nxt;
  logic                 pflag_r, pflag_nxt;
  logic                 last_r, last_nxt;
  logic [1:0]           cnt_r, cnt_nxt;
  logic                 done_r, done_nxt;
  logic [DW-1:0]        b0_r, b0_nxt;
  logic [CW-1:0]        rdidx_r, rdidx_nxt;
  logic                 retv_r, retv_nxt;
  logic [CW-1:0]        retidx_r, retidx_nxt;
  logic [DW-1:0]        w0_r, w0_nxt, w1_r, w1_nxt, w2_r, w2_nxt;
  logic [AW-1:0]        cut_r, cut_nxt;
  logic                 pendv_r, pendv_nxt;
  hsplit_pkg::desc_t    pend_r, pend_nxt;
  logic                 outv_r, outv_nxt;
  hsplit_pkg::desc_t    outd_r, outd_nxt;
  logic                 outl_r, outl_nxt;

  logic [CW-1:0]        fill_e;
  logic [DW-1:0]        val;
  logic                 eval_pt, hit_a, hit_b;
  logic                 out_free, can_push, mark;
  logic [CW-1:0]        lim_ext;
  hsplit_pkg::desc_t    desc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      open_r   <= 1'b0;
      fill_r   <= '0;
      head_r   <= '0;
      base_r   <= '0;
      ts_r     <= '0;
      lim_r    <= '0;
      pknown_r <= 1'b0;
      pflag_r  <= 1'b0;
      last_r   <= 1'b0;
      cnt_r    <= '0;
      done_r   <= 1'b0;
      retv_r   <= 1'b0;
      pendv_r  <= 1'b0;
      outv_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      open_r   <= open_nxt;
      fill_r   <= fill_nxt;
      head_r   <= head_nxt;
      base_r   <= base_nxt;
      ts_r     <= ts_nxt;
      lim_r    <= lim_nxt;
      pknown_r <= pknown_nxt;
      pflag_r  <= pflag_nxt;
      last_r   <= last_nxt;
      cnt_r    <= cnt_nxt;
      done_r   <= done_nxt;
      retv_r   <= retv_nxt;
      pendv_r  <= pendv_nxt;
      outv_r   <= outv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    b0_r     <= b0_nxt;
    rdidx_r  <= rdidx_nxt;
    retidx_r <= retidx_nxt;
    w0_r     <= w0_nxt;
    w1_r     <= w1_nxt;
    w2_r     <= w2_nxt;
    cut_r    <= cut_nxt;
    pend_r   <= pend_nxt;
    outd_r   <= outd_nxt;
    outl_r   <= outl_nxt;
  end

  // out-of-frame bytes read as zero
  assign val      = (retidx_r < fill_r) ? mem_rdata : '0;
  assign lim_ext  = CW'(lim_r);
  assign eval_pt  = retv_r && (retidx_r + CW'(2) <= lim_ext) && (retidx_r[0] == lim_r[0]);
  assign hit_a    = (w0_r == '0) && (w1_r == '0) && (w2_r != '0);
  assign hit_b    = (w0_r == '0) && (val == '0) && (w1_r != '0);
  assign out_free = !outv_r || out_ready;
  assign can_push = !pendv_r || out_free;
  assign mark     = last_r && (CW'(cut_r) == fill_r);
  assign fill_e   = open_r ? fill_r : '0;

  always_comb begin
    desc.off  = hsplit_pkg::OFF_OUT_W'(base_r);
    desc.len  = hsplit_pkg::LEN_W'(cut_r);
    desc.pic  = pflag_r;
    desc.mark = mark;
    desc.ts   = ts_r;
  end

  always_comb begin
    state_nxt  = state_r;
    open_nxt   = open_r;
    fill_nxt   = fill_r;
    head_nxt   = head_r;
    base_nxt   = base_r;
    ts_nxt     = ts_r;
    lim_nxt    = lim_r;
    pknown_nxt = pknown_r;
    pflag_nxt  = pflag_r;
    last_nxt   = last_r;
    cnt_nxt    = cnt_r;
    done_nxt   = done_r;
    b0_nxt     = b0_r;
    rdidx_nxt  = rdidx_r;
    retv_nxt   = 1'b0;
    retidx_nxt = retidx_r;
    w0_nxt     = w0_r;
    w1_nxt     = w1_r;
    w2_nxt     = w2_r;
    cut_nxt    = cut_r;
    pendv_nxt  = pendv_r;
    pend_nxt   = pend_r;
    outv_nxt   = outv_r && !out_ready;
    outd_nxt   = outd_r;
    outl_nxt   = outl_r;
    mem_req.we    = 1'b0;
    mem_req.waddr = head_r + AW'(fill_e);
    mem_req.wdata = in_data_byte;
    mem_req.raddr = head_r;
    in_ready      = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (!open_r) begin
            open_nxt   = 1'b1;
            ts_nxt     = in_frame_timestamp;
            lim_nxt    = frame_limit;
            base_nxt   = '0;
            pknown_nxt = 1'b0;
            pflag_nxt  = 1'b0;
          end
          fill_nxt = fill_e;
          if (fill_e < CW'(hsplit_pkg::WINDOW_BYTES)) begin
            mem_req.we = 1'b1;
            fill_nxt   = fill_e + CW'(1);
          end
          last_nxt  = in_frame_last;
          cnt_nxt   = '0;
          done_nxt  = 1'b0;
          state_nxt = ST_LOOP;
        end
      end
      ST_LOOP: begin
        priority if (cnt_r == 2'd2 || done_r) begin
          state_nxt = ST_FIN;
        end else if (!pknown_r) begin
          priority if (fill_r >= CW'(2)) begin
            state_nxt = ST_PIC0;
          end else if (last_r) begin
            pknown_nxt = 1'b1;
            pflag_nxt  = 1'b0;
          end else begin
            state_nxt = ST_FIN;
          end
        end else if ((last_r && fill_r > lim_ext) ||
                     (!last_r && fill_r >= lim_ext + CW'(2))) begin
          if (lim_r <= AW'(2)) begin
            cut_nxt   = lim_r;
            state_nxt = ST_EMIT;
          end else begin
            rdidx_nxt = lim_ext + CW'(1);
            state_nxt = ST_SRCH;
          end
        end else if (last_r) begin
          cut_nxt   = AW'(fill_r);
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_PIC0: begin
        mem_req.raddr = head_r;
        state_nxt     = ST_PIC1;
      end
      ST_PIC1: begin
        mem_req.raddr = head_r + AW'(1);
        b0_nxt        = mem_rdata;
        state_nxt     = ST_PIC2;
      end
      ST_PIC2: begin
        pknown_nxt = 1'b1;
        pflag_nxt  = (b0_r == '0) && (mem_rdata == '0);
        if ((b0_r == '0) && (mem_rdata == '0)) begin
          head_nxt = head_r + AW'(2);
          fill_nxt = fill_r - CW'(2);
          base_nxt = base_r + OW'(2);
        end
        state_nxt = ST_LOOP;
      end
      ST_SRCH: begin
        mem_req.raddr = head_r + AW'(rdidx_r);
        rdidx_nxt     = rdidx_r - CW'(1);
        retv_nxt      = 1'b1;
        retidx_nxt    = rdidx_r;
        if (retv_r) begin
          w0_nxt = val;
          w1_nxt = w0_r;
          w2_nxt = w1_r;
          if (eval_pt) begin
            priority if (hit_a) begin
              cut_nxt   = AW'(retidx_r + CW'(1));
              state_nxt = ST_EMIT;
            end else if (hit_b) begin
              cut_nxt   = AW'(retidx_r);
              state_nxt = ST_EMIT;
            end else if (retidx_r <= CW'(2)) begin
              cut_nxt   = lim_r;
              state_nxt = ST_EMIT;
            end else begin
              cut_nxt = cut_r;
            end
            if (hit_a || hit_b || retidx_r <= CW'(2)) begin
              retv_nxt = 1'b0;
            end
          end
        end
      end
      ST_EMIT: begin
        if (can_push) begin
          if (pendv_r) begin
            outv_nxt = 1'b1;
            outd_nxt = pend_r;
            outl_nxt = 1'b0;
          end
          pendv_nxt  = 1'b1;
          pend_nxt   = desc;
          head_nxt   = head_r + cut_r;
          fill_nxt   = fill_r - CW'(cut_r);
          base_nxt   = base_r + OW'(cut_r);
          pknown_nxt = 1'b0;
          cnt_nxt    = cnt_r + 2'd1;
          done_nxt   = mark;
          state_nxt  = ST_LOOP;
        end
      end
      ST_FIN: begin
        if (can_push) begin
          if (pendv_r) begin
            outv_nxt  = 1'b1;
            outd_nxt  = pend_r;
            outl_nxt  = 1'b1;
            pendv_nxt = 1'b0;
          end
          if (last_r) begin
            open_nxt   = 1'b0;
            fill_nxt   = '0;
            base_nxt   = '0;
            pknown_nxt = 1'b0;
            pflag_nxt  = 1'b0;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = outv_r;
  assign out_desc  = outd_r;
  assign out_last  = outl_r;

endmodule

[hdl/h263_rtp_packet_splitter.sv]
// channel | dir | transfer payload
// in_ch   | in  | data_byte, frame_last, frame_timestamp
// out_ch  | out | payload_offset, payload_length, picture_start, marker,
//         |     | packet_timestamp, last_result
// apb     | in  | payload size limit at byte address 0
//
// One byte at a time: the byte is written, then the picture-start check and, per
// packet cut, the reverse resync search, which reads one window byte per cycle from
// the window RAM.
// rst_n is synchronous; the window RAM is not cleared, a fill count bounds reads.
// A stalled out_ch holds the block once its pending packet register is full, until the transfer.
module h263_rtp_packet_splitter (
  input  logic                              clk,
  input  logic                              rst_n,
  hsplit_in_if.sink                         in_ch,
  hsplit_out_if.source                      out_ch,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [hsplit_pkg::PADDR_W-1:0]    paddr,
  input  logic [hsplit_pkg::PDATA_W-1:0]    pwdata,
  output logic [hsplit_pkg::PDATA_W-1:0]    prdata,
  output logic                              pready
);

  logic [hsplit_pkg::ADDR_W-1:0] frame_limit;
  hsplit_pkg::mem_req_t          mem_req;
  logic [hsplit_pkg::DATA_W-1:0] mem_rdata;
  hsplit_pkg::desc_t             out_desc;

  hsplit_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .frame_limit (frame_limit)
  );

  hsplit_ram #(
    .WIDTH (hsplit_pkg::DATA_W),
    .DEPTH (hsplit_pkg::WINDOW_BYTES)
  ) u_window (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

  hsplit_ctrl u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_ch.valid),
    .in_ready           (in_ch.ready),
    .in_data_byte       (in_ch.data_byte),
    .in_frame_last      (in_ch.frame_last),
    .in_frame_timestamp (in_ch.frame_timestamp),
    .out_valid          (out_ch.valid),
    .out_ready          (out_ch.ready),
    .out_desc           (out_desc),
    .out_last           (out_ch.last_result),
    .frame_limit        (frame_limit),
    .mem_req            (mem_req),
    .mem_rdata          (mem_rdata)
  );

  assign out_ch.payload_offset   = out_desc.off;
  assign out_ch.payload_length   = out_desc.len;
  assign out_ch.picture_start    = out_desc.pic;
  assign out_ch.marker           = out_desc.mark;
  assign out_ch.packet_timestamp = out_desc.ts;

endmodule

[hdl/hsplit_chk.sv]
module hsplit_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          marker,
  input logic                          last_result,
  input logic [hsplit_pkg::LEN_W-1:0]  payload_length
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(payload_length))
    else $error("result dropped or changed while stalled");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in progress");

  a_mark_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && marker |-> last_result)
    else $error("frame-end packet not last of its item");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind h263_rtp_packet_splitter hsplit_chk u_hsplit_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .marker         (out_ch.marker),
  .last_result    (out_ch.last_result),
  .payload_length (out_ch.payload_length)
);

[bench/h263_rtp_packet_splitter_tb.sv]
module h263_rtp_packet_splitter_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE      = 300;

  typedef struct {
    logic [7:0]  b;
    logic        last;
    logic [31:0] ts;
  } frame_byte_t;

  typedef struct {
    logic [hsplit_pkg::OFF_OUT_W-1:0] off;
    logic [hsplit_pkg::LEN_W-1:0]     len;
    logic                             pic;
    logic                             mark;
    logic [hsplit_pkg::TS_W-1:0]      ts;
    logic                             lastr;
  } pkt_desc_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [hsplit_pkg::PADDR_W-1:0] paddr = '0;
  logic [hsplit_pkg::PDATA_W-1:0] pwdata = '0;
  logic [hsplit_pkg::PDATA_W-1:0] prdata;
  logic pready;

  hsplit_in_if  in_ch();
  hsplit_out_if out_ch();

  h263_rtp_packet_splitter u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  frame_byte_t pending_bytes[$];
  pkt_desc_t   expected_pkts[$];
  int errors = 0;
  int cycles = 0;

  // splitter mirror
  logic [7:0]  win[$];
  logic [23:0] base_off;
  logic [31:0] held_ts;
  logic [11:0] mps_reg;
  int unsigned flim;
  bit fopen, pknown, pflag;

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic int unsigned win_rd(int unsigned i);
    if (i < win.size()) return win[i];
    return 0;
  endfunction

  function automatic void win_drop(int unsigned n);
    if (n > win.size()) n = win.size();
    repeat (n) void'(win.pop_front());
    base_off = base_off + 24'(n);
  endfunction

  function automatic int unsigned resync_cut(int unsigned lim);
    int p;
    for (p = int'(lim) - 1; p > 1; p -= 2) begin
      if (win_rd(p) == 0) begin
        if (win_rd(p + 1) == 0 && win_rd(p + 2) != 0) return p;
        if (win_rd(p - 1) == 0 && win_rd(p + 1) != 0) return p - 1;
      end
    end
    return lim;
  endfunction

  function automatic void push_pkt(int unsigned len, bit mark);
    pkt_desc_t d;
    d.off = base_off;
    d.len = hsplit_pkg::LEN_W'(len);
    d.pic = pflag;
    d.mark = mark;
    d.ts = held_ts;
    d.lastr = 1'b0;
    expected_pkts.push_back(d);
  endfunction

  function automatic void split_byte(frame_byte_t it);
    int n;
    bit done;
    int unsigned m, len, sz;
    n = 0;
    done = 0;
    if (!fopen) begin
      m = mps_reg;
      if (m < hsplit_pkg::MPS_MIN) m = hsplit_pkg::MPS_MIN;
      if (m > hsplit_pkg::WINDOW_BYTES) m = hsplit_pkg::WINDOW_BYTES;
      fopen = 1;
      held_ts = it.ts;
      base_off = '0;
      win.delete();
      pknown = 0;
      pflag = 0;
      flim = m - hsplit_pkg::HDR_BYTES;
    end
    if (win.size() < hsplit_pkg::WINDOW_BYTES) win.push_back(it.b);
    while (n < 2 && !done) begin
      if (!pknown) begin
        if (win.size() >= 2) begin
          pflag = (win[0] == 0 && win[1] == 0);
          pknown = 1;
          if (pflag) win_drop(2);
        end else if (it.last) begin
          pflag = 0;
          pknown = 1;
        end else break;
      end
      if (it.last) begin
        sz = win.size();
        len = sz < flim ? sz : flim;
        if (len < sz) len = resync_cut(len);
        push_pkt(len, len == sz);
        n++;
        win_drop(len);
        pknown = 0;
        if (len == sz) done = 1;
      end else if (win.size() >= flim + 2) begin
        len = resync_cut(flim);
        push_pkt(len, 0);
        n++;
        win_drop(len);
        pknown = 0;
      end else break;
    end
    if (it.last) begin
      fopen = 0;
      win.delete();
      base_off = '0;
      pknown = 0;
      pflag = 0;
    end
    if (n > 0) expected_pkts[$].lastr = 1'b1;
  endfunction

  // input driver
  bit in_fire = 0, out_fire = 0;
  int in_gap = 0, out_stall = 0;
  bit in_calm = 0, out_calm = 0;

  always @(negedge clk) begin
    logic nv;
    frame_byte_t it;
    nv = in_ch.valid;
    if (!rst_n) nv = 1'b0;
    else begin
      if (in_fire) nv = 1'b0;
      if (!nv) begin
        if (in_gap > 0) in_gap--;
        else if (pending_bytes.size() > 0) begin
          it = pending_bytes.pop_front();
          in_ch.data_byte <= it.b;
          in_ch.frame_last <= it.last;
          in_ch.frame_timestamp <= it.ts;
          nv = 1'b1;
          if ($urandom_range(0, 99) == 0) in_calm = ~in_calm;
          in_gap = in_calm ? 0 : $urandom_range(0, 7);
        end
      end
    end
    in_ch.valid <= nv;
  end

  always @(negedge clk) begin
    if (out_fire) begin
      if ($urandom_range(0, 99) == 0) out_calm = ~out_calm;
      out_stall = out_calm ? 0 : $urandom_range(0, 7);
    end
    if (out_stall > 0) begin
      out_stall--;
      out_ch.ready <= 1'b0;
    end else out_ch.ready <= 1'b1;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.frame_last = 1'b0;
    in_ch.frame_timestamp = '0;
    out_ch.ready = 1'b0;
  end

  // monitor
  always @(posedge clk) begin
    pkt_desc_t e;
    bit bad;
    in_fire = rst_n && in_ch.valid && in_ch.ready;
    out_fire = rst_n && out_ch.valid && out_ch.ready;
    if (in_fire)
      split_byte('{in_ch.data_byte, in_ch.frame_last, in_ch.frame_timestamp});
    if (out_fire) begin
      if (expected_pkts.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected packet off=%0d len=%0d",
                                   out_ch.payload_offset, out_ch.payload_length);
      end else begin
        e = expected_pkts.pop_front();
        bad = out_ch.payload_offset !== e.off || out_ch.payload_length !== e.len ||
              out_ch.picture_start !== e.pic || out_ch.marker !== e.mark ||
              out_ch.packet_timestamp !== e.ts || out_ch.last_result !== e.lastr;
        if (bad) begin
          errors++;
          if (errors <= 10)
            $display("mismatch exp off=%0d len=%0d pic=%0b mk=%0b ts=%h lr=%0b, got off=%0d len=%0d pic=%0b mk=%0b ts=%h lr=%0b",
                     e.off, e.len, e.pic, e.mark, e.ts, e.lastr,
                     out_ch.payload_offset, out_ch.payload_length, out_ch.picture_start,
                     out_ch.marker, out_ch.packet_timestamp, out_ch.last_result);
        end
      end
    end
  end

  task automatic cfg_write(logic [hsplit_pkg::PADDR_W-1:0] a,
                           logic [hsplit_pkg::PDATA_W-1:0] v);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= a; pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (a == hsplit_pkg::REG_MAX_PAYLOAD) mps_reg = v[hsplit_pkg::MPS_W-1:0];
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (pending_bytes.size() != 0 || in_ch.valid || expected_pkts.size() != 0)
      @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  function automatic void add_byte(logic [7:0] b, bit last, logic [31:0] ts);
    pending_bytes.push_back('{b, last, ts});
  endfunction

  logic [31:0] cur_ts;

  function automatic void add_frame(int len, bit close);
    int i;
    logic [31:0] ts;
    ts = cur_ts;
    i = 0;
    if ($urandom_range(0, 1) && len >= 2) begin
      add_byte(8'h00, 0, ts);
      add_byte(8'h00, len == 2 && close, ts);
      i = 2;
    end
    while (i < len) begin
      if ($urandom_range(0, 15) == 0) ts = $urandom();
      if ($urandom_range(0, 9) == 0 && i + 3 <= len) begin
        add_byte(8'h00, 0, ts);
        add_byte(8'h00, 0, ts);
        add_byte(8'($urandom_range(1, 255)), close && i + 3 == len, ts);
        i += 3;
      end else begin
        add_byte($urandom_range(0, 2) == 0 ? 8'h00 : 8'($urandom()),
                 close && i + 1 == len, ts);
        i++;
      end
    end
    cur_ts = $urandom();
  endfunction

  int mps_list[9] = '{0, 3, 4, 17, 2048, 4095, 40, 9, 1400};

  initial begin
    int ph, cnt, len, lim;
    fopen = 0; pknown = 0; pflag = 0; flim = 0;
    base_off = '0; held_ts = '0;
    mps_reg = 12'(hsplit_pkg::MPS_RESET);
    cur_ts = 32'hFFFF_FFFF;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: default limit
    add_byte(8'h00, 0, 32'h0);
    add_byte(8'h00, 1, 32'h0);
    add_byte(8'hFF, 1, 32'hFFFF_FFFF);
    add_byte(8'h00, 1, 32'h1234_5678);
    add_byte(8'h00, 0, 32'hA5A5_A5A5);
    add_byte(8'h00, 0, 32'h5A5A_5A5A);
    add_byte(8'h80, 0, 32'h0);
    add_byte(8'h00, 0, 32'h0);
    add_byte(8'h00, 0, 32'h0);
    add_byte(8'h00, 1, 32'h0);
    wait_drained();
    cfg_write(hsplit_pkg::REG_MAX_PAYLOAD, 32'd6);
    cur_ts = 32'h0000_0001;
    add_frame(12, 1);
    add_frame(2, 1);
    wait_drained();

    for (ph = 0; ph < 9; ph++) begin
      cfg_write(hsplit_pkg::REG_MAX_PAYLOAD, mps_list[ph]);
      lim = mps_list[ph] & 12'hFFF;
      if (lim < hsplit_pkg::MPS_MIN) lim = hsplit_pkg::MPS_MIN;
      if (lim > hsplit_pkg::WINDOW_BYTES) lim = hsplit_pkg::WINDOW_BYTES;
      cnt = 0;
      while (cnt < 140) begin
        len = $urandom_range(1, lim < 60 ? 3 * lim + 4 : 60);
        add_frame(len, 1);
        cnt += len;
      end
      // leave a frame open across the next register write, if there is one
      if (ph % 2 == 0) add_frame($urandom_range(1, 5), 0);
      wait_drained();
    end
    add_byte(8'h00, 1, 32'h0);
    wait_drained();

    if (errors == 0 && expected_pkts.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
